/* design/mfa_pkg.sv */
// Shared types and constants for the mixed fraction ALU.
// Used by mfa_ctrl, mfa_dp and mixed_fraction_alu; depends on nothing.
package mfa_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int FIELD_W = 16;
  localparam int IMP_W = 2 * FIELD_W;
  localparam int PROD_W = 2 * IMP_W;
  localparam int DEN_W = 48;
  localparam int RES_NUM_W = 48;
  localparam int RES_DEN_W = 49;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_MUL = 2'd1,
    FUNC_DIV = 2'd2,
    FUNC_NIL = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL_AW,
    OP_ADD_A,
    OP_MUL_BW,
    OP_ADD_B,
    OP_MUL_NUM,
    OP_SET_NUM,
    OP_MUL_DEN,
    OP_SET_DEN,
    OP_MUL_X,
    OP_ADD_NUM,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_TAKE,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    SEL_MAIN,
    SEL_GCD,
    SEL_RN,
    SEL_RD
  } dsel_t;

  typedef enum logic [1:0] {
    OUT_ADD,
    OUT_NIL,
    OUT_DZ
  } osel_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
    osel_t osel;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  bn_zero;
    logic  gy_zero;
    logic  div_last;
  } stat_t;

endpackage

/* design/mixed_fraction_alu.sv */
// From the accepting edge to the done beat, an add runs the product steps and one division;
// operation code 3 or a divide by zero ends after the operand products and the check; multiply
// and divide add the Euclid modulo steps and two reducing divisions; each division is a 64-step radix-2 loop.
// One item at a time: busy drops the cycle after done. The receiver cannot stall.
// Synchronous active-high reset returns the controller to idle.
// Top level of the mixed fraction ALU; depends on mfa_pkg, mfa_ctrl, mfa_dp.
module mixed_fraction_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [1:0]                    func,
  input  logic [15:0]                   a_integer,
  input  logic [15:0]                   a_numerator,
  input  logic [15:0]                   a_denominator,
  input  logic [15:0]                   b_integer,
  input  logic [15:0]                   b_numerator,
  input  logic [15:0]                   b_denominator,
  output logic [63:0]                   res_integer,
  output logic [mfa_pkg::RES_NUM_W-1:0] res_numerator,
  output logic [mfa_pkg::RES_DEN_W-1:0] res_denominator,
  output logic                          div_zero
);

  mfa_pkg::cmd_t  cmd;
  mfa_pkg::stat_t stat;

  mfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mfa_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .stat            (stat),
    .func            (func),
    .a_integer       (a_integer),
    .a_numerator     (a_numerator),
    .a_denominator   (a_denominator),
    .b_integer       (b_integer),
    .b_numerator     (b_numerator),
    .b_denominator   (b_denominator),
    .res_integer     (res_integer),
    .res_numerator   (res_numerator),
    .res_denominator (res_denominator),
    .div_zero        (div_zero)
  );

endmodule

/* design/mfa_dp.sv */
// Datapath of the mixed fraction ALU: operand registers, a shared 32x32
// multiplier and a radix-2 restoring divider used for quotient, Euclid and reduction.
// Depends on mfa_pkg.
module mfa_dp (
  input  logic                        clk,
  input  mfa_pkg::cmd_t               cmd,
  output mfa_pkg::stat_t              stat,
  input  logic [1:0]                  func,
  input  logic [15:0]                 a_integer,
  input  logic [15:0]                 a_numerator,
  input  logic [15:0]                 a_denominator,
  input  logic [15:0]                 b_integer,
  input  logic [15:0]                 b_numerator,
  input  logic [15:0]                 b_denominator,
  output logic [63:0]                 res_integer,
  output logic [mfa_pkg::RES_NUM_W-1:0] res_numerator,
  output logic [mfa_pkg::RES_DEN_W-1:0] res_denominator,
  output logic                        div_zero
);

  localparam int OW = mfa_pkg::OPERAND_WIDTH;
  localparam int FW = mfa_pkg::FIELD_W;
  localparam int IW = mfa_pkg::IMP_W;
  localparam int PW = mfa_pkg::PROD_W;
  localparam int DW = mfa_pkg::DEN_W;

  mfa_pkg::func_t fn;
  logic [FW-1:0] wa, na, da, wb, nb, db;
  logic [IW-1:0] an, bn;
  logic [PW-1:0] prod, num, whole, dq;
  logic [DW-1:0] den, rem, gx, gy, dd, dr, onum;
  logic [mfa_pkg::CNT_W-1:0] cnt;
  logic [IW-1:0] ma, mb;
  logic [DW:0] rr, diff;
  logic ge;
  logic [FW-1:0] a_d, b_d;

  assign a_d = FW'(a_denominator[OW-1:0]);
  assign b_d = FW'(b_denominator[OW-1:0]);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      mfa_pkg::OP_MUL_AW: begin
        ma = IW'(wa);
        mb = IW'(da);
      end
      mfa_pkg::OP_MUL_BW: begin
        ma = IW'(wb);
        mb = IW'(db);
      end
      mfa_pkg::OP_MUL_NUM: begin
        ma = an;
        mb = (fn == mfa_pkg::FUNC_MUL) ? bn : IW'(db);
      end
      mfa_pkg::OP_MUL_DEN: begin
        ma = IW'(da);
        mb = (fn == mfa_pkg::FUNC_DIV) ? bn : IW'(db);
      end
      mfa_pkg::OP_MUL_X: begin
        ma = bn;
        mb = IW'(da);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rr = {dr, dq[PW-1]};
  assign diff = rr - {1'b0, dd};
  assign ge = rr >= {1'b0, dd};

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.op)
      mfa_pkg::OP_CAPTURE: begin
        fn <= mfa_pkg::func_t'(func);
        wa <= FW'(a_integer[OW-1:0]);
        na <= FW'(a_numerator[OW-1:0]);
        da <= (a_d == '0) ? FW'(1) : a_d;
        wb <= FW'(b_integer[OW-1:0]);
        nb <= FW'(b_numerator[OW-1:0]);
        db <= (b_d == '0) ? FW'(1) : b_d;
      end
      mfa_pkg::OP_ADD_A: an <= prod[IW-1:0] + IW'(na);
      mfa_pkg::OP_ADD_B: bn <= prod[IW-1:0] + IW'(nb);
      mfa_pkg::OP_SET_NUM: num <= prod;
      mfa_pkg::OP_SET_DEN: den <= prod[DW-1:0];
      mfa_pkg::OP_ADD_NUM: num <= num + prod;
      mfa_pkg::OP_DIV_LOAD: begin
        dr <= '0;
        cnt <= '1;
        case (cmd.dsel)
          mfa_pkg::SEL_MAIN: begin
            dq <= num;
            dd <= den;
          end
          mfa_pkg::SEL_GCD: begin
            dq <= PW'(gx);
            dd <= gy;
          end
          mfa_pkg::SEL_RN: begin
            dq <= PW'(rem);
            dd <= gx;
          end
          default: begin
            dq <= PW'(den);
            dd <= gx;
          end
        endcase
      end
      mfa_pkg::OP_DIV_STEP: begin
        dr <= ge ? diff[DW-1:0] : rr[DW-1:0];
        dq <= {dq[PW-2:0], ge};
        cnt <= cnt - 1'b1;
      end
      mfa_pkg::OP_TAKE: begin
        case (cmd.dsel)
          mfa_pkg::SEL_MAIN: begin
            whole <= dq;
            rem <= dr;
            gx <= dr;
            gy <= den;
          end
          mfa_pkg::SEL_GCD: begin
            gx <= gy;
            gy <= dr;
          end
          mfa_pkg::SEL_RN: onum <= dq[DW-1:0];
          default: begin
            res_integer <= whole;
            res_numerator <= onum;
            res_denominator <= {1'b0, dq[DW-1:0]};
            div_zero <= 1'b0;
          end
        endcase
      end
      mfa_pkg::OP_OUT: begin
        case (cmd.osel)
          mfa_pkg::OUT_ADD: begin
            res_integer <= whole;
            res_numerator <= rem;
            res_denominator <= {1'b0, den};
            div_zero <= 1'b0;
          end
          mfa_pkg::OUT_DZ: begin
            res_integer <= '0;
            res_numerator <= '0;
            res_denominator <= '0;
            div_zero <= 1'b1;
          end
          default: begin
            res_integer <= '0;
            res_numerator <= '0;
            res_denominator <= mfa_pkg::RES_DEN_W'(1);
            div_zero <= 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign stat.func = fn;
  assign stat.bn_zero = (bn == '0);
  assign stat.gy_zero = (gy == '0);
  assign stat.div_last = (cnt == '0);

endmodule

/* design/mfa_ctrl.sv */
// Controller of the mixed fraction ALU: sequences the datapath through
// operand loading, products, division, the Euclid loop and reduction. Depends on mfa_pkg.
module mfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mfa_pkg::stat_t stat,
  output mfa_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [26:0] {
    S_IDLE   = 27'd1 << 0,
    S_MAW    = 27'd1 << 1,
    S_ADA    = 27'd1 << 2,
    S_MBW    = 27'd1 << 3,
    S_ADB    = 27'd1 << 4,
    S_CHK    = 27'd1 << 5,
    S_MNUM   = 27'd1 << 6,
    S_SNUM   = 27'd1 << 7,
    S_MDEN   = 27'd1 << 8,
    S_SDEN   = 27'd1 << 9,
    S_MX     = 27'd1 << 10,
    S_ANUM   = 27'd1 << 11,
    S_DLD    = 27'd1 << 12,
    S_DSTEP  = 27'd1 << 13,
    S_DTAKE  = 27'd1 << 14,
    S_OADD   = 27'd1 << 15,
    S_GCHK   = 27'd1 << 16,
    S_GLD    = 27'd1 << 17,
    S_GSTEP  = 27'd1 << 18,
    S_GTAKE  = 27'd1 << 19,
    S_NLD    = 27'd1 << 20,
    S_NSTEP  = 27'd1 << 21,
    S_NTAKE  = 27'd1 << 22,
    S_RLD    = 27'd1 << 23,
    S_RSTEP  = 27'd1 << 24,
    S_RTAKE  = 27'd1 << 25,
    S_FIN    = 27'd1 << 26
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = mfa_pkg::OP_NONE;
    cmd.dsel = mfa_pkg::SEL_MAIN;
    cmd.osel = mfa_pkg::OUT_NIL;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = mfa_pkg::OP_CAPTURE;
          state_next = S_MAW;
        end
      end
      S_MAW: begin
        cmd.op = mfa_pkg::OP_MUL_AW;
        state_next = S_ADA;
      end
      S_ADA: begin
        cmd.op = mfa_pkg::OP_ADD_A;
        state_next = S_MBW;
      end
      S_MBW: begin
        cmd.op = mfa_pkg::OP_MUL_BW;
        state_next = S_ADB;
      end
      S_ADB: begin
        cmd.op = mfa_pkg::OP_ADD_B;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.func == mfa_pkg::FUNC_NIL) begin
          cmd.op = mfa_pkg::OP_OUT;
          cmd.osel = mfa_pkg::OUT_NIL;
          state_next = S_FIN;
        end else if (stat.func == mfa_pkg::FUNC_DIV && stat.bn_zero) begin
          cmd.op = mfa_pkg::OP_OUT;
          cmd.osel = mfa_pkg::OUT_DZ;
          state_next = S_FIN;
        end else begin
          state_next = S_MNUM;
        end
      end
      S_MNUM: begin
        cmd.op = mfa_pkg::OP_MUL_NUM;
        state_next = S_SNUM;
      end
      S_SNUM: begin
        cmd.op = mfa_pkg::OP_SET_NUM;
        state_next = S_MDEN;
      end
      S_MDEN: begin
        cmd.op = mfa_pkg::OP_MUL_DEN;
        state_next = S_SDEN;
      end
      S_SDEN: begin
        cmd.op = mfa_pkg::OP_SET_DEN;
        state_next = (stat.func == mfa_pkg::FUNC_ADD) ? S_MX : S_DLD;
      end
      S_MX: begin
        cmd.op = mfa_pkg::OP_MUL_X;
        state_next = S_ANUM;
      end
      S_ANUM: begin
        cmd.op = mfa_pkg::OP_ADD_NUM;
        state_next = S_DLD;
      end
      S_DLD: begin
        cmd.op = mfa_pkg::OP_DIV_LOAD;
        cmd.dsel = mfa_pkg::SEL_MAIN;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = mfa_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_DTAKE;
        end
      end
      S_DTAKE: begin
        cmd.op = mfa_pkg::OP_TAKE;
        cmd.dsel = mfa_pkg::SEL_MAIN;
        state_next = (stat.func == mfa_pkg::FUNC_ADD) ? S_OADD : S_GCHK;
      end
      S_OADD: begin
        cmd.op = mfa_pkg::OP_OUT;
        cmd.osel = mfa_pkg::OUT_ADD;
        state_next = S_FIN;
      end
      S_GCHK: begin
        state_next = stat.gy_zero ? S_NLD : S_GLD;
      end
      S_GLD: begin
        cmd.op = mfa_pkg::OP_DIV_LOAD;
        cmd.dsel = mfa_pkg::SEL_GCD;
        state_next = S_GSTEP;
      end
      S_GSTEP: begin
        cmd.op = mfa_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_GTAKE;
        end
      end
      S_GTAKE: begin
        cmd.op = mfa_pkg::OP_TAKE;
        cmd.dsel = mfa_pkg::SEL_GCD;
        state_next = S_GCHK;
      end
      S_NLD: begin
        cmd.op = mfa_pkg::OP_DIV_LOAD;
        cmd.dsel = mfa_pkg::SEL_RN;
        state_next = S_NSTEP;
      end
      S_NSTEP: begin
        cmd.op = mfa_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_NTAKE;
        end
      end
      S_NTAKE: begin
        cmd.op = mfa_pkg::OP_TAKE;
        cmd.dsel = mfa_pkg::SEL_RN;
        state_next = S_RLD;
      end
      S_RLD: begin
        cmd.op = mfa_pkg::OP_DIV_LOAD;
        cmd.dsel = mfa_pkg::SEL_RD;
        state_next = S_RSTEP;
      end
      S_RSTEP: begin
        cmd.op = mfa_pkg::OP_DIV_STEP;
        if (stat.div_last) begin
          state_next = S_RTAKE;
        end
      end
      S_RTAKE: begin
        cmd.op = mfa_pkg::OP_TAKE;
        cmd.dsel = mfa_pkg::SEL_RD;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The final division hands its quotient over in the cycle before the beat.
  logic rd_take;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_take <= 1'b0;
    end else begin
      rd_take <= (state == S_RTAKE);
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_FIN);

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state is not one-hot");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beat lasted more than one cycle");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  assert property (@(posedge clk) disable iff (rst) rd_take |-> done)
    else $error("reduced result not presented after final division");

endmodule
